// ===== hw/rtl/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types and constants of the weld pool metrics block
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 12;

  // width of the shared divider, covers the 36 bit moment and the shifted area
  localparam int DIV_W = 48;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COM_GO,
    S_COM_WAIT,
    S_PEN_GO,
    S_PEN_WAIT,
    S_MY_GO,
    S_MY_WAIT,
    S_ASYM_GO,
    S_ASYM_WAIT,
    S_DONE
  } wpm_state_t;

  typedef enum logic [1:0] {
    SEL_COM,
    SEL_PEN,
    SEL_MY,
    SEL_ASYM
  } div_sel_t;

  typedef struct packed {
    logic     load_hdr;
    logic     acc_point;
    logic     div_start;
    div_sel_t sel;
    logic     finish;
  } wpm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } wpm_sts_t;

endpackage

// ===== hw/rtl/weld_pool_metrics_core.sv =====
// ----------------------------------------------------------------------------
// weld_pool_metrics_core
// per-frame weld pool metrics from a header item and contour point items
// ----------------------------------------------------------------------------
//  channel   dir   signals                    contents
//  s_*       in    tvalid tready tdata tuser  header or contour point, tlast
//                  tlast                      marks last point of the frame
//  m_*       out   tvalid tready tdata tuser  one result per frame, tuser is
//                                             the result valid flag
//
//  header and non-last point items are taken while ready stays high
//  the last point of a frame runs four divisions in one shared 48 step
//  divider (centroid, index, material y, asymmetry), each issued and
//  awaited in turn: ready stays low until all end and the output is free
//  a finished result waits in the output register while new items flow;
//  the next last point then holds ready low until that result is taken
//  rst is synchronous, active high; the latched header resets to zero
// ----------------------------------------------------------------------------
module weld_pool_metrics_core #(
  parameter int MAX_POINTS = wpm_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = wpm_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // blob_pixel_count[23:0] blob_moment_x[59:24] blob_weight_sum[83:60]
  // blob_top[95:84] blob_bottom[107:96] circle_x[124:108] circle_y[141:125]
  // circle_r[157:142] point_x[169:158] point_y[181:170], zero pad
  input  logic [wpm_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic                           s_tuser,
  // last_point
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // penetration_index[31:0] seam_position[49:32] seam_asymmetry[65:50]
  // material_x[82:66] material_y[94:83], zero pad
  output logic [wpm_pkg::OUT_DATA_W-1:0] m_tdata,
  // result_valid[0]
  output logic                           m_tuser
);
  import wpm_pkg::*;

  wpm_cmd_t cmd;
  wpm_sts_t sts;

  logic [31:0]        penetration_index;
  logic signed [17:0] seam_position;
  logic signed [15:0] seam_asymmetry;
  logic signed [16:0] material_x;
  logic [11:0]        material_y;

  // sequencer: item handshake and division order
  wpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_type  (s_tuser),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: unpack the item fields straight from tdata
  wpm_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .blob_pixel_count  (s_tdata[23:0]),
    .blob_moment_x     (s_tdata[59:24]),
    .blob_weight_sum   (s_tdata[83:60]),
    .blob_top          (s_tdata[95:84]),
    .blob_bottom       (s_tdata[107:96]),
    .circle_x          ($signed(s_tdata[124:108])),
    .circle_y          ($signed(s_tdata[141:125])),
    .circle_r          (s_tdata[157:142]),
    .point_x           (s_tdata[169:158]),
    .point_y           (s_tdata[181:170]),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .penetration_index (penetration_index),
    .seam_position     (seam_position),
    .seam_asymmetry    (seam_asymmetry),
    .material_x        (material_x),
    .material_y        (material_y),
    .result_valid      (m_tuser)
  );

  // result packing, low field first
  assign m_tdata = {1'b0, material_y, material_x, seam_asymmetry, seam_position,
                    penetration_index};

endmodule

// ===== hw/rtl/wpm_div.sv =====
// ----------------------------------------------------------------------------
// wpm_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wpm_div #(
  parameter int W = wpm_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W:0]       rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       rem_shift;
  logic [W:0]       trial;

  assign rem_shift = {rem[W-1:0], quo[W-1]};
  assign trial     = rem_shift - {1'b0, dsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_after: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a run");

endmodule

// ===== hw/rtl/wpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpm_ctrl
// sequencer: takes items, then runs the end of frame divisions in order
// ----------------------------------------------------------------------------
module wpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_type,
  input  logic              in_last,
  output logic              in_ready,
  output wpm_pkg::wpm_cmd_t cmd,
  input  wpm_pkg::wpm_sts_t sts
);
  import wpm_pkg::*;

  wpm_state_t state, state_next;
  logic       hs;

  assign hs = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (hs && in_type && in_last) state_next = S_COM_GO;
      S_COM_GO:    state_next = S_COM_WAIT;
      S_COM_WAIT:  if (sts.div_done) state_next = S_PEN_GO;
      S_PEN_GO:    state_next = S_PEN_WAIT;
      S_PEN_WAIT:  if (sts.div_done) state_next = S_MY_GO;
      S_MY_GO:     state_next = S_MY_WAIT;
      S_MY_WAIT:   if (sts.div_done) state_next = S_ASYM_GO;
      S_ASYM_GO:   state_next = S_ASYM_WAIT;
      S_ASYM_WAIT: if (sts.div_done) state_next = S_DONE;
      S_DONE:      if (sts.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.load_hdr  = hs && !in_type;
    cmd.acc_point = hs && in_type;
    cmd.div_start = 1'b0;
    cmd.sel       = SEL_COM;
    cmd.finish    = 1'b0;
    unique case (state)
      S_COM_GO: begin
        cmd.div_start = 1'b1;
        cmd.sel       = SEL_COM;
      end
      S_PEN_GO: begin
        cmd.div_start = 1'b1;
        cmd.sel       = SEL_PEN;
      end
      S_MY_GO: begin
        cmd.div_start = 1'b1;
        cmd.sel       = SEL_MY;
      end
      S_ASYM_GO: begin
        cmd.div_start = 1'b1;
        cmd.sel       = SEL_ASYM;
      end
      S_DONE:  cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/wpm_dp.sv =====
// ----------------------------------------------------------------------------
// wpm_dp
// datapath: header latch, contour accumulators, divider operands, result
// ----------------------------------------------------------------------------
module wpm_dp #(
  parameter int MAX_POINTS = wpm_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = wpm_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [23:0]        blob_pixel_count,
  input  logic [35:0]        blob_moment_x,
  input  logic [23:0]        blob_weight_sum,
  input  logic [11:0]        blob_top,
  input  logic [11:0]        blob_bottom,
  input  logic signed [16:0] circle_x,
  input  logic signed [16:0] circle_y,
  input  logic [15:0]        circle_r,
  input  logic [11:0]        point_x,
  input  logic [11:0]        point_y,
  input  wpm_pkg::wpm_cmd_t  cmd,
  output wpm_pkg::wpm_sts_t  sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        penetration_index,
  output logic signed [17:0] seam_position,
  output logic signed [15:0] seam_asymmetry,
  output logic signed [16:0] material_x,
  output logic [11:0]        material_y,
  output logic               result_valid
);
  import wpm_pkg::*;

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SW  = COORD_BITS + CW;
  localparam int NB  = ((COORD_BITS > 12) ? COORD_BITS : 12) + 3;
  localparam int MW  = ((COORD_BITS + 4 > 17) ? COORD_BITS + 4 : 17) + 2;
  localparam int SEW = ((COORD_BITS + 5 > 17) ? COORD_BITS + 5 : 17) + 1;

  // latched header
  logic [23:0]        hdr_pixel_count;
  logic [35:0]        hdr_moment_x;
  logic [23:0]        hdr_weight_sum;
  logic [11:0]        hdr_top;
  logic [11:0]        hdr_bottom;
  logic signed [16:0] hdr_circle_x;
  logic signed [16:0] hdr_circle_y;
  logic [15:0]        hdr_circle_r;

  // contour accumulators
  logic [COORD_BITS-1:0] right_x;
  logic [SW-1:0]         sum_y_at_right;
  logic [CW-1:0]         count_at_right;
  logic [CW-1:0]         points_seen;

  // division results
  logic [35:0]           com_q;
  logic [31:0]           pen_q;
  logic [COORD_BITS-1:0] my_q;
  logic signed [15:0]    asym_q;
  div_sel_t              sel_r;

  logic [COORD_BITS-1:0] px, py;
  logic                  div_busy, div_done;
  logic [DIV_W-1:0]      div_dividend, div_divisor, div_q;

  logic signed [41:0]    d;
  logic [41:0]           d_abs;
  logic signed [NB-1:0]  num_base;
  logic [NB-1:0]         num_abs;
  logic signed [12:0]    width_s;
  logic [12:0]           width_abs;
  logic                  asym_neg;
  logic signed [MW-1:0]  s_sum, s_half;
  logic signed [16:0]    mx_c;
  logic signed [SEW-1:0] seam_c;
  logic                  pen_ok, mat_ok, all_ok, my_zero;

  assign px = COORD_BITS'(point_x);
  assign py = COORD_BITS'(point_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pixel_count <= '0;
      hdr_moment_x    <= '0;
      hdr_weight_sum  <= '0;
      hdr_top         <= '0;
      hdr_bottom      <= '0;
      hdr_circle_x    <= '0;
      hdr_circle_y    <= '0;
      hdr_circle_r    <= '0;
    end else if (cmd.load_hdr) begin
      hdr_pixel_count <= blob_pixel_count;
      hdr_moment_x    <= blob_moment_x;
      hdr_weight_sum  <= blob_weight_sum;
      hdr_top         <= blob_top;
      hdr_bottom      <= blob_bottom;
      hdr_circle_x    <= circle_x;
      hdr_circle_y    <= circle_y;
      hdr_circle_r    <= circle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_hdr || cmd.finish) begin
      right_x        <= '0;
      sum_y_at_right <= '0;
      count_at_right <= '0;
      points_seen    <= '0;
    end else if (cmd.acc_point && (points_seen < CW'(MAX_POINTS))) begin
      points_seen <= points_seen + 1'b1;
      if (px == right_x) begin
        sum_y_at_right <= sum_y_at_right + SW'(py);
        count_at_right <= count_at_right + 1'b1;
      end else if (px > right_x) begin
        right_x        <= px;
        sum_y_at_right <= SW'(py);
        count_at_right <= CW'(1);
      end
    end
  end

  // signed distance of centroid and keyhole in 4 fraction bits
  assign d     = $signed({2'b00, com_q, 4'b0000}) - 42'(hdr_circle_x);
  assign d_abs = d[41] ? 42'(-d) : 42'(d);

  assign num_base  = $signed(NB'({my_q, 1'b0})) - $signed(NB'(hdr_bottom))
                   - $signed(NB'(hdr_top));
  assign num_abs   = num_base[NB-1] ? NB'(-num_base) : NB'(num_base);
  assign width_s   = $signed({1'b0, hdr_bottom}) - $signed({1'b0, hdr_top});
  assign width_abs = width_s[12] ? 13'(-width_s) : 13'(width_s);

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd.sel)
      SEL_COM: begin
        div_dividend = DIV_W'(hdr_moment_x);
        div_divisor  = DIV_W'(hdr_weight_sum);
      end
      SEL_PEN: begin
        div_dividend = DIV_W'({hdr_pixel_count, 12'h000});
        div_divisor  = DIV_W'(d_abs);
      end
      SEL_MY: begin
        div_dividend = DIV_W'(sum_y_at_right);
        div_divisor  = DIV_W'(count_at_right);
      end
      SEL_ASYM: begin
        div_dividend = DIV_W'({num_abs, 8'h00});
        div_divisor  = DIV_W'({width_abs, 1'b0});
      end
      default: ;
    endcase
  end

  wpm_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_r    <= cmd.sel;
      asym_neg <= num_base[NB-1] ^ width_s[12];
    end
    if (div_done) begin
      unique case (sel_r)
        SEL_COM: com_q <= 36'(div_q);
        SEL_PEN: pen_q <= (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
        SEL_MY:  my_q  <= COORD_BITS'(div_q);
        SEL_ASYM: begin
          if (!asym_neg) begin
            asym_q <= (div_q > DIV_W'(32767)) ? 16'sh7FFF : $signed(div_q[15:0]);
          end else begin
            asym_q <= (div_q > DIV_W'(32768)) ? 16'sh8000 : 16'(-div_q[15:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // extra material x: halve rounding toward minus infinity, then clamp
  assign s_sum  = $signed(MW'({right_x, 4'b0000})) + MW'(hdr_circle_x)
                + $signed(MW'(hdr_circle_r));
  assign s_half = s_sum >>> 1;
  always_comb begin
    if (s_half > MW'(65535)) begin
      mx_c = 17'sh0FFFF;
    end else if (s_half < -MW'(65536)) begin
      mx_c = 17'sh10000;
    end else begin
      mx_c = 17'(s_half);
    end
  end

  assign seam_c  = $signed(SEW'(hdr_circle_y)) - $signed(SEW'({my_q, 4'b0000}));
  assign pen_ok  = (hdr_weight_sum != '0) && (d != '0);
  assign mat_ok  = pen_ok && (points_seen > CW'(1)) && (count_at_right != '0);
  assign all_ok  = mat_ok && (width_s != '0);
  assign my_zero = (my_q == '0);

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      penetration_index <= pen_ok ? pen_q : 32'h0;
      material_x        <= mat_ok ? mx_c : 17'sh0;
      material_y        <= mat_ok ? 12'(my_q) : 12'h0;
      seam_position     <= (mat_ok && !my_zero) ? 18'(seam_c) : 18'sh0;
      seam_asymmetry    <= (all_ok && !my_zero) ? asym_q : 16'sh0;
      result_valid      <= all_ok;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !(cmd.acc_point || cmd.load_hdr))
    else $error("item taken while dividing");
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("division issued while divider busy");

endmodule
